/* rtl/core/nokc_pkg.sv */
package nokc_pkg;

  // Default longest k-mer and the k-mer length after reset
  localparam int MAX_K_DEFAULT = 8;
  localparam int KLEN_W        = 4;
  localparam logic [KLEN_W-1:0] KMER_LENGTH_RESET = 4'd8;

  // Field widths of one input item
  localparam int FUNC_W = 2;
  localparam int NT_W   = 8;
  localparam int KIDX_W = 16;

  // Field widths of one result item
  localparam int CODE_OUT_W = 16;
  localparam int COUNT_W    = 32;

  // Stream word layout, lowest field first
  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 56;
  localparam int IN_NT_LSB   = 0;
  localparam int IN_KIDX_LSB = IN_NT_LSB + NT_W;
  localparam int OUT_FULL_BIT = 0;
  localparam int OUT_CODE_LSB = 1;
  localparam int OUT_ACC_BIT  = OUT_CODE_LSB + CODE_OUT_W;
  localparam int OUT_CNT_LSB  = OUT_ACC_BIT + 1;
  localparam int OUT_USED_W   = OUT_CNT_LSB + COUNT_W;

  // Item function codes carried in tuser
  typedef enum logic [FUNC_W-1:0] {
    FUNC_NUCLEOTIDE = 2'd0,
    FUNC_END_SEQ    = 2'd1,
    FUNC_READ       = 2'd2,
    FUNC_NONE       = 2'd3
  } func_t;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic accept;   // input transaction taken this cycle
    logic lookup;   // memory read cycle of the current item
    logic finish;   // update memories and load the result register
    logic walk;     // release one ring slot
    logic clear;    // clear one memory entry after reset
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    func_t in_func;    // function of the item offered at the input
    logic  out_free;   // result register can take a result this cycle
    logic  walk_last;  // last ring slot is being released
    logic  clear_last; // last memory entry is being cleared
  } sts_t;

endpackage

/* rtl/core/non_overlapping_kmer_counter_top.sv */
// Channel     Dir  Handshake                Payload
// s_axis      in   tvalid/tready            tuser: func; tdata: nucleotide, kmer_index
// m_axis      out  tvalid/tready            tdata: window_full, kmer_id, accepted,
//                                           count_value
// cfg         in   cfg_we (no wait)         cfg_wdata: kmer_length
//
// A nucleotide, read or unused-code item makes one registered read of the blocked-flag
// and count memories in the lookup state, then a read-modify-write in the update state.
// An end-of-sequence item, and a kmer_length write, walk all MAX_K ring slots, one
// per cycle, before the next item; an end of sequence then also returns a result.
// After rst, a clearing pass writes every memory entry (4**MAX_K of them, 65536 at
// the default) with s_axis_tready low; kmer_length writes are taken meanwhile.
// A stalled result waits in the output register; one more item may then be taken.
module non_overlapping_kmer_counter_top
  import nokc_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // [7:0] nucleotide, [23:8] kmer_index
  input  logic [FUNC_W-1:0]      s_axis_tuser,   // [1:0] func
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [0] window_full, [16:1] kmer_id,
                                                 // [17] accepted, [49:18] count_value
  input  logic                   cfg_we,
  input  logic [KLEN_W-1:0]      cfg_wdata       // kmer_length
);

  cmd_t cmd;
  sts_t sts;

  nokc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .cfg_we   (cfg_we),
    .sts      (sts),
    .cmd      (cmd)
  );

  nokc_dp #(.MAX_K(MAX_K)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .s_tdata   (s_axis_tdata),
    .s_tuser   (s_axis_tuser),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .m_tvalid  (m_axis_tvalid),
    .m_tready  (m_axis_tready),
    .m_tdata   (m_axis_tdata)
  );

endmodule

/* rtl/core/nokc_ram.sv */
module nokc_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read, old data on a same-address write
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

/* rtl/core/nokc_ctrl.sv */
module nokc_ctrl
  import nokc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic cfg_we,
  input  sts_t sts,
  output cmd_t cmd
);

  typedef enum logic [4:0] {
    ST_CLEAR  = 5'b00001,
    ST_IDLE   = 5'b00010,
    ST_LOOKUP = 5'b00100,
    ST_UPDATE = 5'b01000,
    ST_WALK   = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   cfg_pend, cfg_pend_next;
  logic   walk_item, walk_item_next;
  logic   accept;
  logic   finish;

  // Take a new item when idle, or while the current one hands off its result, unless a kmer_length write is pending
  assign finish   = (state == ST_UPDATE) && sts.out_free;
  assign in_ready = !cfg_pend && ((state == ST_IDLE) || finish);
  assign accept   = in_valid && in_ready;

  assign cmd.accept = accept;
  assign cmd.lookup = (state == ST_LOOKUP);
  assign cmd.finish = finish;
  assign cmd.walk   = (state == ST_WALK);
  assign cmd.clear  = (state == ST_CLEAR);

  // Next state
  always_comb begin
    state_next     = state;
    walk_item_next = walk_item;
    cfg_pend_next  = cfg_pend || cfg_we;
    unique case (state)
      ST_CLEAR: begin
        if (sts.clear_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cfg_pend) begin
          state_next     = ST_WALK;
          walk_item_next = 1'b0;
          cfg_pend_next  = cfg_we;
        end else if (accept) begin
          if (sts.in_func == FUNC_END_SEQ) begin
            state_next     = ST_WALK;
            walk_item_next = 1'b1;
          end else begin
            state_next = ST_LOOKUP;
          end
        end
      end
      ST_LOOKUP: begin
        state_next = ST_UPDATE;
      end
      ST_UPDATE: begin
        if (finish) begin
          if (accept) begin
            if (sts.in_func == FUNC_END_SEQ) begin
              state_next     = ST_WALK;
              walk_item_next = 1'b1;
            end else begin
              state_next = ST_LOOKUP;
            end
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_WALK: begin
        if (sts.walk_last) begin
          state_next = walk_item ? ST_UPDATE : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      cfg_pend  <= 1'b0;
      walk_item <= 1'b0;
    end else begin
      state     <= state_next;
      cfg_pend  <= cfg_pend_next;
      walk_item <= walk_item_next;
    end
  end

endmodule

/* rtl/core/nokc_dp.sv */
module nokc_dp
  import nokc_pkg::*;
#(
  parameter int MAX_K = MAX_K_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  cmd_t                   cmd,
  output sts_t                   sts,
  input  logic [IN_TDATA_W-1:0]  s_tdata,
  input  logic [FUNC_W-1:0]      s_tuser,
  input  logic                   cfg_we,
  input  logic [KLEN_W-1:0]      cfg_wdata,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata
);

  localparam int CW    = 2 * MAX_K;
  localparam int DEPTH = 1 << CW;
  localparam int RPW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam logic [KLEN_W-1:0] MAXK_L  = KLEN_W'(MAX_K);
  localparam logic [RPW-1:0]    LAST_RP = RPW'(MAX_K - 1);

  // Configuration and sequence state
  logic [KLEN_W-1:0] kmer_length;
  logic [CW-1:0]     window_code;
  logic [KLEN_W-1:0] fill_level;
  logic [RPW-1:0]    ring_pointer;
  logic [MAX_K-1:0]  slot_valid;
  logic [CW-1:0]     slot_code [MAX_K];

  // Current item
  func_t          func_q;
  logic [CW-1:0]  code_q;
  logic           full_q;
  logic [RPW-1:0] rp_q;
  logic           hit_q;

  // Sweep counters
  logic [CW-1:0]  clr_cnt;
  logic [RPW-1:0] walk_idx;

  // Memory ports
  logic           blk_we, blk_wdata, blk_rdata;
  logic [CW-1:0]  blk_waddr;
  logic           cnt_we;
  logic [CW-1:0]  cnt_waddr;
  logic [COUNT_W-1:0] cnt_wdata, cnt_rdata;

  // Combinational item logic
  func_t             in_func;
  logic [NT_W-1:0]   in_nt;
  logic [KIDX_W-1:0] in_kidx;
  logic [1:0]        nt_b, nt_code;
  logic [KLEN_W-1:0] keff;
  logic [CW-1:0]     wmask;
  logic [CW+1:0]     shifted;
  logic [CW-1:0]     window_next;
  logic [KLEN_W-1:0] fill_next;
  logic              full_next;
  logic [RPW-1:0]    rp_eff, rp_inc, rp_next;
  logic [KIDX_W+CW-1:0] kidx_ext;
  logic [RPW-1:0]    sidx;
  logic              s_valid;
  logic [CW-1:0]     s_code;
  logic              count_it;
  logic [COUNT_W-1:0] cnt_inc;
  logic [CW+CODE_OUT_W-1:0] code_ext;
  logic              r_full, r_acc;
  logic [CODE_OUT_W-1:0] r_code;
  logic [COUNT_W-1:0] r_cnt;

  assign in_func = func_t'(s_tuser);
  assign in_nt   = s_tdata[IN_NT_LSB +: NT_W];
  assign in_kidx = s_tdata[IN_KIDX_LSB +: KIDX_W];

  // Clamp k into 1..MAX_K
  always_comb begin
    if (kmer_length == '0) begin
      keff = KLEN_W'(1);
    end else if (kmer_length > MAXK_L) begin
      keff = MAXK_L;
    end else begin
      keff = kmer_length;
    end
  end

  // Map the nucleotide byte and shift it into the window
  assign nt_b    = in_nt[2:1];
  assign nt_code = {nt_b[1], nt_b[1] ^ nt_b[0]};

  always_comb begin
    for (int i = 0; i < CW; i++) begin
      wmask[i] = (i < 2 * int'(keff));
    end
  end

  assign shifted     = {window_code, nt_code};
  assign window_next = shifted[CW-1:0] & wmask;
  assign fill_next   = (fill_level < keff) ? fill_level + KLEN_W'(1) : fill_level;
  assign full_next   = (fill_next >= keff);

  // Ring pointer wraps at k
  assign rp_eff  = (int'(ring_pointer) >= int'(keff)) ? '0 : ring_pointer;
  assign rp_inc  = rp_eff + RPW'(1);
  assign rp_next = (int'(rp_eff) + 1 >= int'(keff)) ? '0 : rp_inc;

  assign kidx_ext = {{CW{1'b0}}, in_kidx};

  // One shared read of the ring slots
  assign sidx    = cmd.walk ? walk_idx : rp_q;
  assign s_valid = slot_valid[sidx];
  assign s_code  = slot_code[sidx];

  // Count the k-mer unless still blocked; a release this item overrides the flag
  assign count_it = (func_q == FUNC_NUCLEOTIDE) && full_q && !(blk_rdata && !hit_q);
  assign cnt_inc  = (cnt_rdata == '1) ? cnt_rdata : cnt_rdata + COUNT_W'(1);

  // Blocked-flag write port
  always_comb begin
    blk_we    = 1'b0;
    blk_waddr = code_q;
    blk_wdata = 1'b0;
    if (cmd.clear) begin
      blk_we    = 1'b1;
      blk_waddr = clr_cnt;
    end else if (cmd.walk) begin
      blk_we    = s_valid;
      blk_waddr = s_code;
    end else if (cmd.lookup) begin
      blk_we    = (func_q == FUNC_NUCLEOTIDE) && full_q && s_valid;
      blk_waddr = s_code;
    end else if (cmd.finish) begin
      blk_we    = count_it;
      blk_wdata = 1'b1;
    end
  end

  // Count write port
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = code_q;
    cnt_wdata = '0;
    if (cmd.clear) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_cnt;
    end else if (cmd.finish) begin
      if (count_it) begin
        cnt_we    = 1'b1;
        cnt_wdata = cnt_inc;
      end else if (func_q == FUNC_READ) begin
        cnt_we = 1'b1;
      end
    end
  end

  nokc_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_blocked (
    .clk   (clk),
    .we    (blk_we),
    .waddr (blk_waddr),
    .wdata (blk_wdata),
    .raddr (code_q),
    .rdata (blk_rdata)
  );

  nokc_ram #(.WIDTH(COUNT_W), .DEPTH(DEPTH)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (code_q),
    .rdata (cnt_rdata)
  );

  // Result fields
  assign code_ext = {{CODE_OUT_W{1'b0}}, code_q};

  always_comb begin
    r_full = 1'b0;
    r_acc  = 1'b0;
    r_code = '0;
    r_cnt  = '0;
    case (func_q)
      FUNC_NUCLEOTIDE: begin
        r_code = code_ext[CODE_OUT_W-1:0];
        if (full_q) begin
          r_full = 1'b1;
          r_acc  = count_it;
          r_cnt  = count_it ? cnt_inc : cnt_rdata;
        end
      end
      FUNC_READ: begin
        r_code = code_ext[CODE_OUT_W-1:0];
        r_cnt  = cnt_rdata;
      end
      default: begin
        r_code = '0;
      end
    endcase
  end

  // Latch the item at acceptance
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      func_q <= in_func;
      full_q <= (in_func == FUNC_NUCLEOTIDE) && full_next;
      rp_q   <= rp_eff;
      if (in_func == FUNC_READ) begin
        code_q <= kidx_ext[CW-1:0];
      end else begin
        code_q <= window_next;
      end
    end
    if (cmd.lookup) begin
      hit_q <= s_valid && (s_code == code_q);
    end
  end

  // Window, fill level, ring pointer and k
  always_ff @(posedge clk) begin
    if (rst) begin
      kmer_length  <= KMER_LENGTH_RESET;
      window_code  <= '0;
      fill_level   <= '0;
      ring_pointer <= '0;
    end else if (cfg_we) begin
      kmer_length  <= cfg_wdata;
      window_code  <= '0;
      fill_level   <= '0;
      ring_pointer <= '0;
    end else if (cmd.accept && (in_func == FUNC_END_SEQ)) begin
      window_code  <= '0;
      fill_level   <= '0;
      ring_pointer <= '0;
    end else if (cmd.accept && (in_func == FUNC_NUCLEOTIDE)) begin
      window_code <= window_next;
      fill_level  <= fill_next;
      if (full_next) begin
        ring_pointer <= rp_next;
      end
    end
  end

  // Ring slots: drop on walk or lookup, record a counted k-mer
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= '0;
    end else if (cmd.walk) begin
      slot_valid[walk_idx] <= 1'b0;
    end else if (cmd.lookup && (func_q == FUNC_NUCLEOTIDE) && full_q) begin
      slot_valid[rp_q] <= 1'b0;
    end else if (cmd.finish && count_it) begin
      slot_valid[rp_q] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && count_it) begin
      slot_code[rp_q] <= code_q;
    end
  end

  // Sweep counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt  <= '0;
      walk_idx <= '0;
    end else begin
      if (cmd.clear) begin
        clr_cnt <= clr_cnt + CW'(1);
      end
      walk_idx <= cmd.walk ? walk_idx + RPW'(1) : '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.finish) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      m_tdata <= {(OUT_TDATA_W - OUT_USED_W)'(0), r_cnt, r_acc, r_code, r_full};
    end
  end

  assign sts.in_func    = in_func;
  assign sts.out_free   = !m_tvalid || m_tready;
  assign sts.walk_last  = (walk_idx == LAST_RP);
  assign sts.clear_last = (clr_cnt == '1);

endmodule

/* rtl/core/nokc_checker.sv */
module nokc_checker
  import nokc_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  logic in_xfer;
  assign in_xfer = s_axis_tvalid && s_axis_tready;

  // Clearing pass holds the input off right after reset
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> !s_axis_tready)
    else $error("input ready during the clearing pass");

  // Input ready is low right after every input transaction
  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> !s_axis_tready)
    else $error("input ready right after a transaction");

  // A counted occurrence belongs to a full window and leaves a nonzero count
  a_accepted_fields: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tdata[OUT_ACC_BIT]) |->
      (m_axis_tdata[OUT_FULL_BIT] && (m_axis_tdata[OUT_CNT_LSB +: COUNT_W] != '0)))
    else $error("accepted result without a full window or with a zero count");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind non_overlapping_kmer_counter_top nokc_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

/* verif/tb.sv */
module tb;
  import nokc_pkg::*;

  localparam int KMAX           = MAX_K_DEFAULT;
  localparam int STORE_SIZE     = 1 << (2 * KMAX);
  localparam int WATCHDOG_LIMIT = 400000;
  localparam int PRINT_LIMIT    = 20;

  // One expected result, field by field
  typedef struct packed {
    bit        window_full;
    bit [15:0] kmer_id;
    bit        accepted;
    bit [31:0] count_value;
  } kmer_result_t;

  // Shadow copy of the counter plus the queue of results it predicts
  class kmer_scoreboard;
    bit [KLEN_W-1:0] klen_reg;
    int unsigned     window;
    int unsigned     fill;
    int unsigned     ring_ptr;
    bit              slot_valid [KMAX];
    int unsigned     slot_code [KMAX];
    bit              blocked [STORE_SIZE];
    bit [31:0]       counts [STORE_SIZE];
    kmer_result_t    expected_q [$];
    int              errors;

    function new();
      klen_reg = KMER_LENGTH_RESET;
      errors   = 0;
      release_all();
    endfunction

    function int unsigned kmer_len_eff();
      if (klen_reg == 0) return 1;
      if (klen_reg > KMAX) return KMAX;
      return klen_reg;
    endfunction

    // Drop all blocks and restart the window
    function void release_all();
      for (int i = 0; i < KMAX; i++) begin
        if (slot_valid[i]) blocked[slot_code[i]] = 1'b0;
        slot_valid[i] = 1'b0;
        slot_code[i]  = 0;
      end
      window   = 0;
      fill     = 0;
      ring_ptr = 0;
    endfunction

    function void set_kmer_length(bit [KLEN_W-1:0] v);
      klen_reg = v;
      release_all();
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Advance the shadow state by one accepted input transaction
    function void note_input(func_t f, bit [7:0] nt, bit [15:0] idx);
      kmer_result_t r;
      int unsigned  k, rp, wmask, c;
      bit [1:0]     b, base;
      r = '0;
      case (f)
        FUNC_NUCLEOTIDE: begin
          k     = kmer_len_eff();
          wmask = (1 << (2 * k)) - 1;
          b     = nt[2:1];
          base  = b ^ {1'b0, b[1]};
          window = ((window << 2) | base) & wmask;
          r.kmer_id = 16'(window);
          if (fill < k) fill++;
          if (fill >= k) begin
            rp = (ring_ptr >= k) ? 0 : ring_ptr;
            r.window_full = 1'b1;
            // free the block that ends at this position
            if (slot_valid[rp]) blocked[slot_code[rp]] = 1'b0;
            slot_valid[rp] = 1'b0;
            slot_code[rp]  = 0;
            if (!blocked[window]) begin
              if (counts[window] != 32'hFFFF_FFFF) counts[window] = counts[window] + 1;
              blocked[window] = 1'b1;
              slot_valid[rp]  = 1'b1;
              slot_code[rp]   = window;
              r.accepted      = 1'b1;
            end
            r.count_value = counts[window];
            ring_ptr = (rp + 1 >= k) ? 0 : rp + 1;
          end
        end
        FUNC_END_SEQ: release_all();
        FUNC_READ: begin
          c = idx & (STORE_SIZE - 1);
          r.kmer_id     = 16'(c);
          r.count_value = counts[c];
          counts[c]     = '0;
        end
        default: ;
      endcase
      expected_q.push_back(r);
    endfunction

    task report(string msg);
      errors++;
      if (errors <= PRINT_LIMIT) $display("mismatch: %s", msg);
    endtask

    // Compare one output transaction with the oldest expectation
    task check_result(logic [OUT_TDATA_W-1:0] d);
      kmer_result_t e;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result %h", d));
        return;
      end
      e = expected_q.pop_front();
      if (d[OUT_FULL_BIT] !== e.window_full)
        report($sformatf("window_full %b, want %b", d[OUT_FULL_BIT], e.window_full));
      if (d[OUT_CODE_LSB +: CODE_OUT_W] !== e.kmer_id)
        report($sformatf("kmer_id %h, want %h", d[OUT_CODE_LSB +: CODE_OUT_W], e.kmer_id));
      if (d[OUT_ACC_BIT] !== e.accepted)
        report($sformatf("accepted %b, want %b (code %h)", d[OUT_ACC_BIT], e.accepted,
                         e.kmer_id));
      if (d[OUT_CNT_LSB +: COUNT_W] !== e.count_value)
        report($sformatf("count_value %0d, want %0d (code %h)", d[OUT_CNT_LSB +: COUNT_W],
                         e.count_value, e.kmer_id));
    endtask
  endclass

  logic                   clk;
  logic                   rst;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [IN_TDATA_W-1:0]  s_axis_tdata;
  logic [FUNC_W-1:0]      s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic                   cfg_we;
  logic [KLEN_W-1:0]      cfg_wdata;

  kmer_scoreboard sb = new();
  int             idle_cycles = 0;
  bit             tx_calm = 1'b0;
  bit [15:0]      recent_codes [$];
  string          letters = "ACGTacgt";
  bit [7:0]       motif [4];
  int             motif_len = 0;
  int             motif_pos = 0;
  int             phase_klen [11] = '{1, 0, 15, 3, 2, 5, 8, 4, 12, 6, 7};

  non_overlapping_kmer_counter_top #(.MAX_K(KMAX)) u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Mostly short idles, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Offer one item, hold it until taken, then log it in the scoreboard
  task automatic send_item(func_t f, bit [7:0] nt, bit [15:0] idx);
    int gap;
    gap = tx_calm ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {idx, nt};
    s_axis_tuser  <= f;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    sb.note_input(f, nt, idx);
    if (f == FUNC_NUCLEOTIDE) begin
      recent_codes.push_back(16'(sb.window));
      if (recent_codes.size() > 16) void'(recent_codes.pop_front());
    end
  endtask

  // Hold the sender until every expected result is back
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_kmer_length(bit [KLEN_W-1:0] v);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.set_kmer_length(v);
  endtask

  // Pick the next base: either from a short repeating motif or at random
  function automatic bit [7:0] next_base();
    bit [7:0] nt;
    if ($urandom_range(0, 99) < 4) return 8'($urandom_range(0, 255));
    if (motif_len == 0 || $urandom_range(0, 99) < 3)
      return letters[$urandom_range(0, 7)];
    nt = motif[motif_pos];
    motif_pos = (motif_pos + 1) % motif_len;
    return nt;
  endfunction

  function automatic void new_motif();
    motif_len = $urandom_range(0, 4);
    motif_pos = 0;
    for (int i = 0; i < 4; i++) motif[i] = letters[$urandom_range(0, 7)];
  endfunction

  task automatic random_item();
    int       r;
    func_t    f;
    bit [7:0] nt;
    bit [15:0] idx;
    r   = $urandom_range(0, 99);
    nt  = 8'($urandom_range(0, 255));
    idx = 16'($urandom_range(0, 65535));
    if (r < 72) begin
      f  = FUNC_NUCLEOTIDE;
      nt = next_base();
    end else if (r < 79) begin
      f = FUNC_END_SEQ;
      new_motif();
    end else if (r < 97) begin
      f = FUNC_READ;
      if (recent_codes.size() > 0 && $urandom_range(0, 3) != 0)
        idx = recent_codes[$urandom_range(0, recent_codes.size() - 1)];
    end else begin
      f = FUNC_NONE;
    end
    send_item(f, nt, idx);
  endtask

  // Stall the result side at random, with long stretches of no stall
  initial begin : rx_stall
    int run, stall;
    forever begin
      m_axis_tready <= 1'b1;
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300) : $urandom_range(1, 12);
      repeat (run) @(posedge clk);
      stall = pick_gap();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
    end
  end

  // Check every output transaction
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
      idle_cycles <= 0;
    else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: FAIL");
        $finish;
      end
    end
  end

  initial begin
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= FUNC_NUCLEOTIDE;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: reset length, extreme bytes, both cases, partial and full windows
    send_item(FUNC_NUCLEOTIDE, 8'h00, 16'h0000);
    send_item(FUNC_NUCLEOTIDE, 8'hFF, 16'hFFFF);
    send_item(FUNC_NUCLEOTIDE, "a", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "C", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "g", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "T", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "A", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "c", 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "G", 16'h0000);
    // read a live count twice: the second read sees it cleared
    send_item(FUNC_READ, 8'hFF, 16'(sb.window));
    send_item(FUNC_READ, 8'h00, 16'(sb.window));
    send_item(FUNC_READ, 8'h00, 16'hFFFF);
    send_item(FUNC_NONE, 8'hFF, 16'hFFFF);
    send_item(FUNC_END_SEQ, 8'h00, 16'h0000);
    drain();

    // Directed: short k on a homopolymer, so blocks form and expire
    write_kmer_length(4'd2);
    repeat (6) send_item(FUNC_NUCLEOTIDE, "A", 16'h0000);
    send_item(FUNC_READ, 8'h00, 16'h0000);
    send_item(FUNC_END_SEQ, 8'h00, 16'h0000);
    send_item(FUNC_NUCLEOTIDE, "t", 16'h0000);
    send_item(FUNC_READ, 8'h00, 16'h0000);
    drain();

    // Random phases, one k setting each
    foreach (phase_klen[p]) begin
      write_kmer_length(4'(phase_klen[p]));
      tx_calm = (p % 4 == 3);
      new_motif();
      repeat (102) random_item();
      drain();
    end

    repeat (2 * KMAX + 8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("tb: PASS");
    else
      $display("tb: FAIL");
    $finish;
  end

endmodule

/* files.f */
rtl/core/nokc_pkg.sv
rtl/core/nokc_ram.sv
rtl/core/nokc_ctrl.sv
rtl/core/nokc_dp.sv
rtl/core/non_overlapping_kmer_counter_top.sv
rtl/core/nokc_checker.sv
verif/tb.sv
